[hw/rtl/sitda_pkg.sv]
// Shared types and constants for the signed integer to decimal ASCII block.
// Holds widths, character codes and the controller/datapath interface structs.
// No dependencies.
`default_nettype none

package sitda_pkg;

  localparam int VALUE_BITS = 32;
  // Decimal digits needed for 2^(VALUE_BITS-1); 1233/4096 approximates log10(2).
  localparam int DIGITS     = ((VALUE_BITS * 1233) >> 12) + 1;
  localparam int BCD_W      = DIGITS * 4;
  localparam int STEP_W     = $clog2(VALUE_BITS + 1);
  localparam int DIG_W      = $clog2(DIGITS + 1);

  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_MINUS = 8'd45;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // capture a new value and clear the BCD register
    logic shift;       // one add-3 / shift step
    logic skip;        // drop a leading zero digit
    logic emit_sign;   // load '-' into the output register
    logic emit_digit;  // load the top digit into the output register
    logic last;        // last_char flag for an emitted digit
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic neg;         // captured value is negative
    logic top_zero;    // top BCD digit is zero
    logic out_free;    // output register can take a character this cycle
  } sts_t;

endpackage

`default_nettype wire

[hw/rtl/sitda_datapath.sv]
// Datapath: magnitude shift register, BCD register with add-3 correction,
// and the output register. Depends on sitda_pkg.
`default_nettype none

module sitda_datapath (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic signed [sitda_pkg::VALUE_BITS-1:0] value,
  input  wire sitda_pkg::cmd_t                     cmd,
  output sitda_pkg::sts_t                          sts,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [7:0]                               character,
  output logic                                     last_char
);

  logic [sitda_pkg::VALUE_BITS-1:0] raw;
  logic [sitda_pkg::VALUE_BITS-1:0] mag;
  logic [sitda_pkg::VALUE_BITS-1:0] bin;
  logic [sitda_pkg::BCD_W-1:0]      bcd;
  logic [sitda_pkg::BCD_W-1:0]      bcd_adj;
  logic                             neg;
  logic [3:0]                       top_digit;

  assign raw = value;
  assign mag = raw[sitda_pkg::VALUE_BITS-1]
             ? (~raw + {{(sitda_pkg::VALUE_BITS-1){1'b0}}, 1'b1}) : raw;

  // Add 3 to every digit of 5 or more before the shift.
  always_comb begin
    for (int i = 0; i < sitda_pkg::DIGITS; i++) begin
      bcd_adj[i*4 +: 4] = (bcd[i*4 +: 4] >= 4'd5) ? (bcd[i*4 +: 4] + 4'd3) : bcd[i*4 +: 4];
    end
  end

  assign top_digit = bcd[sitda_pkg::BCD_W-1 -: 4];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      bin <= mag;
      bcd <= '0;
      neg <= raw[sitda_pkg::VALUE_BITS-1];
    end else if (cmd.shift) begin
      bin <= {bin[sitda_pkg::VALUE_BITS-2:0], 1'b0};
      bcd <= {bcd_adj[sitda_pkg::BCD_W-2:0], bin[sitda_pkg::VALUE_BITS-1]};
    end else if (cmd.skip || cmd.emit_digit) begin
      bcd <= {bcd[sitda_pkg::BCD_W-5:0], 4'd0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_sign || cmd.emit_digit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_sign) begin
      character <= sitda_pkg::CH_MINUS;
      last_char <= 1'b0;
    end else if (cmd.emit_digit) begin
      character <= sitda_pkg::CH_ZERO + {4'd0, top_digit};
      last_char <= cmd.last;
    end
  end

  assign sts.neg      = neg;
  assign sts.top_zero = (top_digit == 4'd0);
  assign sts.out_free = !out_valid || out_ready;

endmodule

`default_nettype wire

[hw/rtl/sitda_ctrl.sv]
// Controller: sequences conversion steps, leading-zero skipping and
// character emission. Depends on sitda_pkg.
`default_nettype none

module sitda_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire sitda_pkg::sts_t  sts,
  output sitda_pkg::cmd_t       cmd
);

  typedef enum logic [4:0] {
    S_IDLE    = 5'b00001,
    S_CONVERT = 5'b00010,
    S_SKIP    = 5'b00100,
    S_SIGN    = 5'b01000,
    S_EMIT    = 5'b10000
  } state_t;

  state_t                        state, state_next;
  logic [sitda_pkg::STEP_W-1:0]  step_cnt, step_cnt_next;
  logic [sitda_pkg::DIG_W-1:0]   dig_cnt, dig_cnt_next;
  logic                          last_dig;

  assign last_dig = (dig_cnt == sitda_pkg::DIG_W'(1));

  always_comb begin
    state_next    = state;
    step_cnt_next = step_cnt;
    dig_cnt_next  = dig_cnt;
    cmd           = '0;
    in_ready      = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load      = 1'b1;
          step_cnt_next = sitda_pkg::STEP_W'(sitda_pkg::VALUE_BITS);
          dig_cnt_next  = sitda_pkg::DIG_W'(sitda_pkg::DIGITS);
          state_next    = S_CONVERT;
        end
      end
      S_CONVERT: begin
        cmd.shift     = 1'b1;
        step_cnt_next = step_cnt - sitda_pkg::STEP_W'(1);
        if (step_cnt == sitda_pkg::STEP_W'(1)) begin
          state_next = S_SKIP;
        end
      end
      S_SKIP: begin
        if (sts.top_zero && !last_dig) begin
          cmd.skip     = 1'b1;
          dig_cnt_next = dig_cnt - sitda_pkg::DIG_W'(1);
        end else begin
          state_next = sts.neg ? S_SIGN : S_EMIT;
        end
      end
      S_SIGN: begin
        if (sts.out_free) begin
          cmd.emit_sign = 1'b1;
          state_next    = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit_digit = 1'b1;
          cmd.last       = last_dig;
          dig_cnt_next   = dig_cnt - sitda_pkg::DIG_W'(1);
          if (last_dig) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    step_cnt <= step_cnt_next;
    dig_cnt  <= dig_cnt_next;
  end

endmodule

`default_nettype wire

[hw/rtl/signed_int_to_decimal_ascii.sv]
// Top level of the signed integer to decimal ASCII converter.
// Instantiates sitda_ctrl and sitda_datapath; uses sitda_pkg.
//
// Usage:
//   Input channel (value, in_valid, in_ready) takes one signed 32-bit integer
//   per transaction. Output channel (character, last_char, out_valid,
//   out_ready) delivers its decimal text one ASCII character per transaction,
//   most significant first: '-' for a negative value, then the digits with
//   leading zeros dropped. last_char marks the final digit; zero gives "0".
//   Timing: after an input transaction the magnitude goes through binary to
//   BCD conversion, one shift-add-3 step per cycle and one step per input
//   bit. Leading zero digits are then dropped at one per cycle (up to 9),
//   and characters leave at one per cycle while the receiver keeps up.
//   in_ready returns in the cycle after the last character is loaded. The
//   block handles one item at a time.
//   The output register releases a character whenever it is empty or being
//   taken, so a stalled receiver simply holds the sequence; no character is
//   dropped or repeated. Reset (rst, synchronous, active high) returns the
//   controller to idle and empties the output register.
`default_nettype none

module signed_int_to_decimal_ascii (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  input  wire logic signed [sitda_pkg::VALUE_BITS-1:0] value,
  input  wire logic                                    in_valid,
  output logic                                         in_ready,
  output logic [7:0]                                   character,
  output logic                                         last_char,
  output logic                                         out_valid,
  input  wire logic                                    out_ready
);

  // Command and status between sequencer and datapath.
  sitda_pkg::cmd_t cmd;
  sitda_pkg::sts_t sts;

  sitda_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sitda_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .value     (value),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .character (character),
    .last_char (last_char)
  );

endmodule

`default_nettype wire
